>>> rtl/jscs_pkg.sv
// ----------------------------------------------------------------------------
// JSON structure ceiling scan package
// Shared types, byte codes, verdict codes and register indexes.
// ----------------------------------------------------------------------------
package jscs_pkg;

	// Field widths.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned DEPTH_W  = 8;
	localparam int unsigned NODE_W   = 24;
	localparam int unsigned OFFSET_W = 24;
	localparam int unsigned LEVEL_W  = DEPTH_W + 1;
	localparam int unsigned TOTAL_W  = NODE_W + 1;
	localparam int unsigned REG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 24;

	// Largest message handled; the byte offset saturates one below it.
	localparam longint unsigned MSG_LEN_LIMIT = 64'd16777216;
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = OFFSET_W'(MSG_LEN_LIMIT - 64'd1);

	// Reset values of the limit registers.
	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RESET = DEPTH_W'(64);
	localparam logic [NODE_W-1:0]  NODE_LIMIT_RESET  = NODE_W'(65536);

	// Register indexes on the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_DEPTH_LIMIT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_NODE_LIMIT  = 1'b1;

	// Structural bytes.
	localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CHAR_QUOTE     = 8'h22;
	localparam logic [BYTE_W-1:0] CHAR_LBRACKET  = 8'h5B;
	localparam logic [BYTE_W-1:0] CHAR_LBRACE    = 8'h7B;
	localparam logic [BYTE_W-1:0] CHAR_RBRACKET  = 8'h5D;
	localparam logic [BYTE_W-1:0] CHAR_RBRACE    = 8'h7D;
	localparam logic [BYTE_W-1:0] CHAR_COMMA     = 8'h2C;

	// Reject codes.
	typedef enum logic [1:0] {
		VERDICT_OK    = 2'd0,
		VERDICT_DEPTH = 2'd1,
		VERDICT_NODES = 2'd2
	} verdict_t;

	// One result request.
	typedef struct packed {
		verdict_t              verdict;
		logic [OFFSET_W-1:0]   reject_offset;
		logic                  message_done;
	} result_t;

endpackage

>>> rtl/jscs_scan.sv
// ----------------------------------------------------------------------------
// JSON structure scan core
// Holds the limit registers and the scan state; updates the scan state for
// each accepted byte, producing one result per byte.
// ----------------------------------------------------------------------------
module jscs_scan (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               write_enable,
	input  logic [jscs_pkg::REG_IDX_W-1:0]     register_index,
	input  logic [jscs_pkg::CFG_DATA_W-1:0]    write_data,
	input  logic                               accept,
	input  logic [jscs_pkg::BYTE_W-1:0]        data_byte,
	input  logic                               end_of_message,
	output jscs_pkg::result_t                  result
);

	logic [jscs_pkg::DEPTH_W-1:0]  depth_limit_q;
	logic [jscs_pkg::NODE_W-1:0]   node_limit_q;

	logic                          inside_string_q, inside_string_d;
	logic                          escape_pending_q, escape_pending_d;
	logic [jscs_pkg::LEVEL_W-1:0]  nesting_level_q, nesting_level_d;
	logic [jscs_pkg::TOTAL_W-1:0]  node_total_q, node_total_d;
	logic [jscs_pkg::OFFSET_W-1:0] byte_position_q, byte_position_d;
	jscs_pkg::verdict_t            reject_code_q, reject_code_d;
	logic [jscs_pkg::OFFSET_W-1:0] breach_offset_q, breach_offset_d;

	logic [jscs_pkg::LEVEL_W-1:0]  level_inc;
	logic [jscs_pkg::TOTAL_W-1:0]  total_inc;
	logic                          depth_over;
	logic                          nodes_over;

	// Limit registers, written by the user only while idle; not enforced here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q <= jscs_pkg::DEPTH_LIMIT_RESET;
			node_limit_q  <= jscs_pkg::NODE_LIMIT_RESET;
		end else if (write_enable) begin
			case (register_index)
				jscs_pkg::REG_DEPTH_LIMIT: begin
					depth_limit_q <= write_data[jscs_pkg::DEPTH_W-1:0];
				end
				jscs_pkg::REG_NODE_LIMIT: begin
					node_limit_q <= write_data[jscs_pkg::NODE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Incremented counters and their limit checks.
	assign level_inc  = nesting_level_q + jscs_pkg::LEVEL_W'(1);
	assign total_inc  = node_total_q + jscs_pkg::TOTAL_W'(1);
	assign depth_over = level_inc > {1'b0, depth_limit_q};
	assign nodes_over = total_inc > {1'b0, node_limit_q};

	// Next scan state for the current byte; after a breach only the offset moves.
	always_comb begin
		inside_string_d  = inside_string_q;
		escape_pending_d = escape_pending_q;
		nesting_level_d  = nesting_level_q;
		node_total_d     = node_total_q;
		reject_code_d    = reject_code_q;
		breach_offset_d  = breach_offset_q;

		if (reject_code_q == jscs_pkg::VERDICT_OK) begin
			if (inside_string_q) begin
				if (escape_pending_q) begin
					escape_pending_d = 1'b0;
				end else if (data_byte == jscs_pkg::CHAR_BACKSLASH) begin
					escape_pending_d = 1'b1;
				end else if (data_byte == jscs_pkg::CHAR_QUOTE) begin
					inside_string_d = 1'b0;
				end
			end else if (data_byte == jscs_pkg::CHAR_QUOTE) begin
				inside_string_d = 1'b1;
			end else if (data_byte == jscs_pkg::CHAR_LBRACKET ||
					data_byte == jscs_pkg::CHAR_LBRACE) begin
				nesting_level_d = level_inc;
				if (depth_over) begin
					reject_code_d   = jscs_pkg::VERDICT_DEPTH;
					breach_offset_d = byte_position_q;
				end else begin
					node_total_d = total_inc;
					if (nodes_over) begin
						reject_code_d   = jscs_pkg::VERDICT_NODES;
						breach_offset_d = byte_position_q;
					end
				end
			end else if (data_byte == jscs_pkg::CHAR_RBRACKET ||
					data_byte == jscs_pkg::CHAR_RBRACE) begin
				if (nesting_level_q != '0) begin
					nesting_level_d = nesting_level_q - jscs_pkg::LEVEL_W'(1);
				end
			end else if (data_byte == jscs_pkg::CHAR_COMMA) begin
				node_total_d = total_inc;
				if (nodes_over) begin
					reject_code_d   = jscs_pkg::VERDICT_NODES;
					breach_offset_d = byte_position_q;
				end
			end
		end

		// The byte offset saturates on very long messages.
		if (byte_position_q != jscs_pkg::OFFSET_MAX) begin
			byte_position_d = byte_position_q + jscs_pkg::OFFSET_W'(1);
		end else begin
			byte_position_d = byte_position_q;
		end
	end

	// The result shows the verdict including this byte.
	assign result.verdict       = reject_code_d;
	assign result.reject_offset = breach_offset_d;
	assign result.message_done  = end_of_message;

	// Scan state; the final byte of a message clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_string_q  <= 1'b0;
			escape_pending_q <= 1'b0;
			nesting_level_q  <= '0;
			node_total_q     <= '0;
			byte_position_q  <= '0;
			reject_code_q    <= jscs_pkg::VERDICT_OK;
			breach_offset_q  <= '0;
		end else if (accept) begin
			if (end_of_message) begin
				inside_string_q  <= 1'b0;
				escape_pending_q <= 1'b0;
				nesting_level_q  <= '0;
				node_total_q     <= '0;
				byte_position_q  <= '0;
				reject_code_q    <= jscs_pkg::VERDICT_OK;
				breach_offset_q  <= '0;
			end else begin
				inside_string_q  <= inside_string_d;
				escape_pending_q <= escape_pending_d;
				nesting_level_q  <= nesting_level_d;
				node_total_q     <= node_total_d;
				byte_position_q  <= byte_position_d;
				reject_code_q    <= reject_code_d;
				breach_offset_q  <= breach_offset_d;
			end
		end
	end

endmodule

>>> rtl/jscs_out_buf.sv
// ----------------------------------------------------------------------------
// JSON structure scan output buffer
// Result register with a skid entry, so the input side stalls only from a
// registered flag and keeps taking bytes while one result waits.
// ----------------------------------------------------------------------------
module jscs_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  jscs_pkg::result_t  push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output jscs_pkg::result_t  out_data
);

	logic              main_valid_q;
	logic              skid_valid_q;
	jscs_pkg::result_t main_q;
	jscs_pkg::result_t skid_q;
	logic              pop;

	assign pop       = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Occupancy flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

>>> rtl/json_structure_ceiling_scan.sv
// ----------------------------------------------------------------------------
// JSON structure ceiling scan
// Bounds JSON nesting depth and node count, one byte a cycle when not stalled.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock cycle while in_stall is low and
// returns one result per accepted byte through a registered output. That
// rate is set by the scan state update (string and escape flags, depth, node
// count, byte offset). A result register with a skid entry sits on the
// output, so the input side stalls only when both entries hold results. The
// limit registers are to be written through the write port only while no byte
// is in flight, which the block itself does not enforce. The first breach
// of a limit is reported with its byte offset until the message's last byte.
module json_structure_ceiling_scan (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               write_enable,
	input  logic [jscs_pkg::REG_IDX_W-1:0]     register_index,
	input  logic [jscs_pkg::CFG_DATA_W-1:0]    write_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [jscs_pkg::BYTE_W-1:0]        data_byte,
	input  logic                               end_of_message,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         verdict,
	output logic [jscs_pkg::OFFSET_W-1:0]      reject_offset,
	output logic                               message_done
);

	logic              accept;
	jscs_pkg::result_t scan_result;
	jscs_pkg::result_t out_result;

	// A byte request is taken whenever the skid entry is free.
	assign accept = in_valid && !in_stall;

	jscs_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.write_enable   (write_enable),
		.register_index (register_index),
		.write_data     (write_data),
		.accept         (accept),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.result         (scan_result)
	);

	jscs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (scan_result),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_result)
	);

	assign verdict       = out_result.verdict;
	assign reject_offset = out_result.reject_offset;
	assign message_done  = out_result.message_done;

`ifndef NO_ASSERTIONS
	// The input side only stalls while a result is waiting at the output.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	// After every accepted byte a result is waiting at the output in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted byte produced no result");

	// A clean verdict never carries a breach offset.
	a_clean_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict == jscs_pkg::VERDICT_OK) |-> reject_offset == '0)
		else $error("breach offset shown without a reject code");
`endif

endmodule
